[sv/rmt_pkg.sv]
// shared constants, types and cell commands for the running median tracker
package rmt_pkg;

  localparam int CAPACITY    = 1024;
  localparam int DATA_W      = 32;
  localparam int HELD_W      = 11;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CHAIN_DEPTH = (CAPACITY + 1) / 2;
  localparam int SIZE_W      = $clog2(CHAIN_DEPTH + 1);
  localparam int OUT_TDATA_W = ((DATA_W + HELD_W + 7) / 8) * 8;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
  localparam logic [OP_W-1:0] OP_INS    = 2'd1;
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd2;
  localparam logic [OP_W-1:0] OP_POPINS = 2'd3;

  // what one cell shows its neighbors
  typedef struct packed {
    logic              pass;
    logic [DATA_W-1:0] value;
  } link_t;

  // command broadcast to every cell of one chain
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] ins_val;
    logic [DATA_W-1:0] push_val;
  } chain_cmd_t;

endpackage

[sv/running_median_tracker.sv]
// running median tracker top level: two insertion chains and the median output
//
// Input channel in_*: one unsigned 32-bit sample per item in in_tdata.
// Output channel out_*: one result item per accepted sample, carrying the
// median of all values held, the number held and a drop flag in out_tuser.
// The store is split into two chains of cells: the lower half kept largest
// first, the upper half kept smallest first, so the middle values always sit
// in the two head cells. Every cell compares its value against the sample in
// parallel and shifts by one toward or away from the head, so the result of an
// accepted sample is registered and valid in the following cycle.
// Throughput is one item per cycle while out_tready is high; each chain cell
// does its cell compare and neighbor select combinationally.
// Once CAPACITY values are held, further samples leave the store untouched
// and their result has the drop flag set.
// Reset clears the count and the output valid; cell contents are not cleared
// and are never read before they are written.
// While out_tready is low a pending result holds and in_tready stays low.
module running_median_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] sample
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rmt_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] median, [42:32] held
  output logic                            out_tuser   // [0] dropped
);
  import rmt_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              dropped_r;
  logic              dropped_nxt;
  logic              in_fire;
  logic              full;
  logic [DATA_W-1:0] sample;
  logic [DATA_W-1:0] lo_head;
  logic [DATA_W-1:0] up_head;
  logic [SIZE_W-1:0] lo_size;
  logic [SIZE_W-1:0] up_size;
  chain_cmd_t        lo_cmd;
  chain_cmd_t        up_cmd;
  logic [DATA_W:0]   mid_sum;
  logic [DATA_W-1:0] median;

  assign sample    = in_tdata[DATA_W-1:0];
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));

  // lower chain holds the ceiling of half the count, upper the floor
  assign lo_size = SIZE_W'(({1'b0, count_r} + (CNT_W + 1)'(1)) >> 1);
  assign up_size = SIZE_W'(count_r >> 1);

  always_comb begin
    lo_cmd        = '{op: OP_HOLD, ins_val: sample, push_val: up_head};
    up_cmd        = '{op: OP_HOLD, ins_val: sample, push_val: lo_head};
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      dropped_nxt   = full;
      if (!full) begin
        count_nxt = count_r + CNT_W'(1);
        if (!count_r[0]) begin
          // lower half grows: sample goes low, or the upper head moves down
          if (count_r == '0 || sample <= up_head) begin
            lo_cmd.op = OP_INS;
          end else begin
            lo_cmd.op = OP_PUSH;
            up_cmd.op = OP_POPINS;
          end
        end else begin
          // upper half grows: sample goes high, or the lower head moves up
          if (sample >= lo_head) begin
            up_cmd.op = OP_INS;
          end else begin
            up_cmd.op = OP_PUSH;
            lo_cmd.op = OP_POPINS;
          end
        end
      end
    end
  end

  rmt_chain u_lo_chain (
    .clk        (clk),
    .descending (1'b1),
    .size       (lo_size),
    .cmd        (lo_cmd),
    .head       (lo_head)
  );

  rmt_chain u_up_chain (
    .clk        (clk),
    .descending (1'b0),
    .size       (up_size),
    .cmd        (up_cmd),
    .head       (up_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dropped_r <= dropped_nxt;
  end

  // 33-bit sum so the mean of the two middle values never wraps
  assign mid_sum = {1'b0, lo_head} + {1'b0, up_head};
  assign median  = count_r[0] ? lo_head : mid_sum[DATA_W:1];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - DATA_W - HELD_W)'(0), HELD_W'(count_r), median};
  assign out_tuser  = dropped_r;

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full) |=> (dropped_r && count_r == CNT_W'(CAPACITY)))
    else $error("sample dropped without a full store or store changed");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !full) |=> (!dropped_r && count_r == $past(count_r) + CNT_W'(1)))
    else $error("held count did not advance by one on a stored sample");

  a_halves_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_r >= CNT_W'(2)) |-> (lo_head <= up_head))
    else $error("lower half head above upper half head");

endmodule

[sv/rmt_cell.sv]
// one storage cell of a sorted insertion chain
module rmt_cell (
  input  logic               clk,
  input  logic               is_head,
  input  logic               descending,
  input  logic               occ,
  input  rmt_pkg::chain_cmd_t cmd,
  input  rmt_pkg::link_t     left_i,
  input  rmt_pkg::link_t     right_i,
  output rmt_pkg::link_t     link_o
);
  import rmt_pkg::*;

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              after_v;
  logic              pass;

  always_comb begin
    // pass: this cell's value belongs behind the new value (empty cells always pass)
    after_v = descending ? (val_r < cmd.ins_val) : (val_r > cmd.ins_val);
    pass    = !occ || after_v;
    link_o  = '{pass: pass, value: val_r};
  end

  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      OP_INS: begin
        if (pass) begin
          val_nxt = left_i.pass ? left_i.value : cmd.ins_val;
        end
      end
      OP_PUSH: begin
        val_nxt = left_i.value;
      end
      OP_POPINS: begin
        // drop the head, everything slides one toward the head, new value goes in
        if (right_i.pass) begin
          val_nxt = (pass && !is_head) ? val_r : cmd.ins_val;
        end else begin
          val_nxt = right_i.value;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[sv/rmt_chain.sv]
// row of cells holding one half of the store in order, head at cell 0
module rmt_chain (
  input  logic                       clk,
  input  logic                       descending,
  input  logic [rmt_pkg::SIZE_W-1:0] size,
  input  rmt_pkg::chain_cmd_t        cmd,
  output logic [rmt_pkg::DATA_W-1:0] head
);
  import rmt_pkg::*;

  link_t links [CHAIN_DEPTH];
  logic  occ   [CHAIN_DEPTH];

  for (genvar i = 0; i < CHAIN_DEPTH; i++) begin : g_cell
    link_t left_l;
    link_t right_l;

    assign occ[i] = (SIZE_W'(i) < size);

    if (i == 0) begin : g_first
      // a push enters through the head's left side
      assign left_l = '{pass: 1'b0, value: cmd.push_val};
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end

    if (i == CHAIN_DEPTH - 1) begin : g_last
      assign right_l = '{pass: 1'b1, value: '0};
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end

    rmt_cell u_cell (
      .clk        (clk),
      .is_head    (i == 0),
      .descending (descending),
      .occ        (occ[i]),
      .cmd        (cmd),
      .left_i     (left_l),
      .right_i    (right_l),
      .link_o     (links[i])
    );
  end

  assign head = links[0].value;

endmodule

[tb/testbench.sv]
// testbench for the running median tracker: directed table, random samples, scoreboard
module testbench;
  import rmt_pkg::*;

  localparam int RAND_ITEMS  = 1936;
  localparam int QUIET_TAIL  = 200;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 600;
  localparam int DRAIN_WAIT  = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int EXP_DEPTH   = 2048;

  typedef struct packed {
    logic [DATA_W-1:0] median;
    logic [HELD_W-1:0] held;
    logic              dropped;
  } median_result_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              known;
    median_result_t    result;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [31:0]            in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  running_median_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // own copy of the sorted store and its fill count
  logic [DATA_W-1:0] sorted_vals [0:CAPACITY-1];
  int                fill_cnt;

  // expected results in order of acceptance, one slot per item sent
  median_result_t exp_results [0:EXP_DEPTH-1];
  int             exp_wr = 0;
  int             exp_rd = 0;
  stim_row_t      dir_rows [0:13];

  int  mismatch_count = 0;
  int  samples_sent   = 0;
  int  drops_seen     = 0;
  int  peak_held      = 0;
  int  cycle_count    = 0;
  bit  quiet_tail     = 1'b0;
  bit  long_hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // insert one sample and work out the median of what is held afterwards
  function automatic median_result_t insert_and_median(input logic [DATA_W-1:0] s);
    median_result_t r;
    int             pos;
    int             mid;
    logic [DATA_W:0] pair_sum;
    r = '0;
    if (fill_cnt >= CAPACITY) begin
      r.dropped = 1'b1;
    end else begin
      pos = fill_cnt;
      while (pos > 0 && sorted_vals[pos-1] > s) begin
        sorted_vals[pos] = sorted_vals[pos-1];
        pos--;
      end
      sorted_vals[pos] = s;
      fill_cnt++;
    end
    mid = fill_cnt / 2;
    if (fill_cnt % 2 == 1) begin
      r.median = sorted_vals[mid];
    end else begin
      pair_sum = {1'b0, sorted_vals[mid-1]} + {1'b0, sorted_vals[mid]};
      r.median = pair_sum[DATA_W:1];
    end
    r.held = HELD_W'(fill_cnt);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 15);
      6: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      7, 8:    v = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: v = 32'h7FFF_FFF8 + $urandom_range(0, 15);
    endcase
    return v;
  endfunction

  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_sample(input stim_row_t row);
    median_result_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= row.sample;
    do @(posedge clk); while (!in_tready);
    predicted = insert_and_median(row.sample);
    exp_results[exp_wr] = row.known ? row.result : predicted;
    exp_wr++;
    samples_sent++;
  endtask

  // stimulus
  initial begin
    stim_row_t row;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    fill_cnt  = 0;
    // max values twice: the even sum must not wrap
    dir_rows = '{
      '{32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 11'd1, 1'b0}},
      '{32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 11'd2, 1'b0}},
      '{32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 11'd3, 1'b0}},
      '{32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 11'd4, 1'b0}},
      '{32'h0000_0005, 1'b1, '{32'h0000_0005, 11'd5, 1'b0}},
      '{32'h0000_0005, 1'b1, '{32'h0000_0005, 11'd6, 1'b0}},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'h0000_0001, 1'b0, '0},
      '{32'hFFFF_FFFE, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'h0000_0003, 1'b0, '0},
      '{32'h0000_0003, 1'b0, '0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      sender_gap();
      send_sample(dir_rows[i]);
    end
    // random part; once the store is full every further sample is dropped
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n >= RAND_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;
      sender_gap();
      row = '0;
      row.sample = pick_sample();
      send_sample(row);
    end
    in_tvalid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d samples sent, %0d results flagged as dropped, peak held count %0d",
             samples_sent, drops_seen, peak_held);
    $display("long receiver hold applied: %0d", long_hold_done);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side backpressure, with one long hold that backs up the input
  initial begin
    out_tready <= 1'b0;
    forever begin
      if (!long_hold_done && samples_sent >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // scoreboard
  always @(posedge clk) begin
    median_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_rd == exp_wr) begin
        $display("%0t: result with nothing expected: median %h held %0d dropped %0b",
                 $time, out_tdata[31:0], out_tdata[42:32], out_tuser);
        mismatch_count++;
      end else begin
        want = exp_results[exp_rd];
        exp_rd++;
        if (out_tdata[31:0] !== want.median) begin
          $display("%0t: median expected %h actual %h", $time, want.median, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[42:32] !== want.held) begin
          $display("%0t: held expected %0d actual %0d", $time, want.held, out_tdata[42:32]);
          mismatch_count++;
        end
        if (out_tuser !== want.dropped) begin
          $display("%0t: dropped expected %0b actual %0b", $time, want.dropped, out_tuser);
          mismatch_count++;
        end
      end
      if (out_tuser === 1'b1) drops_seen++;
      if (int'(out_tdata[42:32]) > peak_held) peak_held = int'(out_tdata[42:32]);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
